[hw/rtl/lsd_pkg.sv]
// Package: shared types and constants of the local standard deviation block.
`timescale 1ns / 1ps
package lsd_pkg;

  localparam int WIN_ROWS  = 5;
  localparam int WIN_AREA  = 25;
  localparam int WIN_HALF  = 2;
  localparam int SUM_W     = 13;
  localparam int SS_W      = 21;
  localparam int VAR_W     = 16;
  localparam int MEAN_MUL  = 5243;
  localparam int MEAN_SHR  = 17;
  localparam int VAR_MUL   = 41943;
  localparam int VAR_SHR   = 20;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MEAN,
    ST_SQ,
    ST_MUL,
    ST_CORR,
    ST_SQRT,
    ST_OUT
  } lsd_state_t;

endpackage

[hw/rtl/lsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 5120
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/local_std_dev_5x5.sv]
// Top level: streaming 5x5 local standard deviation over a line store RAM.
// Sequence: a result is computed after its last window pixel is accepted, in steps
// (window reads, mean, 25 squares, two divide steps, 8 square root steps, output).
// Throughput: one pixel per cycle when it causes no result; else input stalls until
// its results are out, set by the line store's single read port and serial squaring.
// Reset: synchronous; counters clear, sizes return to 640 x 480; RAM keeps data.
`timescale 1ns / 1ps
module local_std_dev_5x5
  import lsd_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           gray,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [9:0]           center_row,
  output logic [9:0]           center_col,
  output logic [7:0]           std_dev,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int CB    = $clog2(MAX_WIDTH);
  localparam int RB    = $clog2(MAX_HEIGHT);
  localparam int SW    = ((CB > RB) ? CB : RB) + 2;
  localparam int DEPTH = WIN_ROWS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  typedef logic signed [SW-1:0] coord_t;

  lsd_state_t state, state_next;

  logic [CFG_DAT_W-1:0] frame_width, frame_height;
  coord_t w_eff, h_eff;
  coord_t row_count, col_count;
  logic [2:0] row_slot;

  coord_t cur_r, r_hi, c_hi, c_lo, cen_r, cen_c;
  logic [2:0] cur_slot;

  logic [2:0] iss_dy, iss_dx;
  logic       iss_done, rd_vld;
  logic [4:0] dcnt, idx;
  logic [7:0] px [WIN_AREA];
  logic [SUM_W-1:0] sum;
  logic [7:0] mean;
  logic [SS_W-1:0] ss;
  logic [SS_W+15:0] prod;
  logic [SS_W-1:0] quo;
  logic [VAR_W-1:0] var_q;
  logic [7:0] sq_res;
  logic [2:0] sq_bit;

  logic accept, cfg_hit, wrap;
  coord_t R_in, C_in, rhi_in, chi_in;
  logic [2:0] slot_in;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] rdata;

  function automatic coord_t eff_size(logic [CFG_DAT_W-1:0] v, int maxv);
    coord_t e;
    if (v == '0) e = coord_t'(1);
    else if (32'(v) > maxv) e = coord_t'(maxv);
    else e = coord_t'(v);
    return e;
  endfunction

  assign w_eff     = eff_size(frame_width, MAX_WIDTH);
  assign h_eff     = eff_size(frame_height, MAX_HEIGHT);
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_hit   = cfg_valid && cfg_ready &&
                     (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_comb begin
    wrap    = (row_count >= h_eff) || (col_count >= w_eff);
    R_in    = wrap ? '0 : row_count;
    C_in    = wrap ? '0 : col_count;
    slot_in = wrap ? 3'd0 : row_slot;
    rhi_in  = (R_in == h_eff - 1) ? R_in : R_in - coord_t'(WIN_HALF);
    chi_in  = (C_in == w_eff - 1) ? C_in : C_in - coord_t'(WIN_HALF);
    waddr   = AW'(32'(slot_in) * MAX_WIDTH + 32'(C_in));
  end

  // window address generation
  coord_t rr, cc, rdiff;
  logic [3:0] slot_sum;
  logic [2:0] rslot;
  always_comb begin
    rr = cen_r + coord_t'(iss_dy) - coord_t'(WIN_HALF);
    if (rr < 0) rr = '0;
    else if (rr > h_eff - 1) rr = h_eff - coord_t'(1);
    cc = cen_c + coord_t'(iss_dx) - coord_t'(WIN_HALF);
    if (cc < 0) cc = '0;
    else if (cc > w_eff - 1) cc = w_eff - coord_t'(1);
    rdiff    = cur_r - rr;
    slot_sum = 4'(cur_slot) + 4'(WIN_ROWS) - 4'(rdiff[2:0]);
    rslot    = (slot_sum >= 4'(WIN_ROWS)) ? 3'(slot_sum - 4'(WIN_ROWS)) : slot_sum[2:0];
    raddr    = AW'(32'(rslot) * MAX_WIDTH + 32'(cc));
  end

  lsd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_line_store (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (gray),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic is_last;
  assign is_last = (cen_r == r_hi) && (cen_c == c_hi);

  logic [7:0] dsub, trial;
  assign dsub  = (px[idx] >= mean) ? px[idx] - mean : mean - px[idx];
  assign trial = sq_res | (8'd1 << sq_bit);

  always_comb begin
    quo = SS_W'(prod >> VAR_SHR);
    if (ss - SS_W'(quo * SS_W'(WIN_AREA)) >= SS_W'(WIN_AREA)) quo = quo + 1'b1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && rhi_in >= 0 && chi_in >= 0) state_next = ST_READ;
      ST_READ: if (rd_vld && dcnt == 5'(WIN_AREA - 1)) state_next = ST_MEAN;
      ST_MEAN: state_next = ST_SQ;
      ST_SQ:   if (idx == 5'(WIN_AREA - 1)) state_next = ST_MUL;
      ST_MUL:  state_next = ST_CORR;
      ST_CORR: state_next = ST_SQRT;
      ST_SQRT: if (sq_bit == 3'd0) state_next = ST_OUT;
      ST_OUT:  if (!out_stall) state_next = is_last ? ST_IDLE : ST_READ;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_DAT_W'(640);
      frame_height <= CFG_DAT_W'(480);
      row_count    <= '0;
      col_count    <= '0;
      row_slot     <= '0;
      rd_vld       <= 1'b0;
      iss_done     <= 1'b0;
    end else begin
      rd_vld <= (state == ST_READ) && !iss_done;
      if (cfg_hit) begin
        if (cfg_index == REG_FRAME_WIDTH) frame_width <= cfg_data;
        else frame_height <= cfg_data;
        row_count <= '0;
        col_count <= '0;
        row_slot  <= '0;
      end else if (accept) begin
        if (C_in + 1 >= w_eff) begin
          col_count <= '0;
          if (R_in + 1 >= h_eff) begin
            row_count <= '0;
            row_slot  <= '0;
          end else begin
            row_count <= R_in + coord_t'(1);
            row_slot  <= (slot_in == 3'(WIN_ROWS - 1)) ? 3'd0 : slot_in + 3'd1;
          end
        end else begin
          col_count <= C_in + coord_t'(1);
        end
      end
      if (state != ST_READ) begin
        iss_done <= 1'b0;
      end else if (iss_dy == 3'(WIN_ROWS - 1) && iss_dx == 3'(WIN_ROWS - 1)) begin
        iss_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r    <= R_in;
      cur_slot <= slot_in;
      r_hi     <= rhi_in;
      c_hi     <= chi_in;
      c_lo     <= (C_in < 2) ? '0 : C_in - coord_t'(WIN_HALF);
      cen_r    <= (R_in < 2) ? '0 : R_in - coord_t'(WIN_HALF);
      cen_c    <= (C_in < 2) ? '0 : C_in - coord_t'(WIN_HALF);
    end
    if (state != ST_READ) begin
      iss_dy <= '0;
      iss_dx <= '0;
      dcnt   <= '0;
      sum    <= '0;
    end else begin
      if (!iss_done) begin
        if (iss_dx == 3'(WIN_ROWS - 1)) begin
          iss_dx <= '0;
          if (iss_dy != 3'(WIN_ROWS - 1)) iss_dy <= iss_dy + 3'd1;
        end else begin
          iss_dx <= iss_dx + 3'd1;
        end
      end
      if (rd_vld) begin
        px[dcnt] <= rdata;
        sum      <= sum + SUM_W'(rdata);
        dcnt     <= dcnt + 5'd1;
      end
    end
    if (state == ST_MEAN) begin
      mean <= 8'((32'(sum) * MEAN_MUL) >> MEAN_SHR);
      idx  <= '0;
      ss   <= '0;
    end
    if (state == ST_SQ) begin
      ss  <= ss + SS_W'(16'(dsub) * 16'(dsub));
      idx <= idx + 5'd1;
    end
    if (state == ST_MUL) begin
      prod <= (SS_W + 16)'(ss) * (SS_W + 16)'(VAR_MUL);
    end
    if (state == ST_CORR) begin
      var_q  <= VAR_W'(quo);
      sq_res <= '0;
      sq_bit <= 3'd7;
    end
    if (state == ST_SQRT) begin
      if (16'(trial) * 16'(trial) <= var_q) sq_res <= trial;
      sq_bit <= sq_bit - 3'd1;
    end
    if (state == ST_OUT && !out_stall && !is_last) begin
      if (cen_c == c_hi) begin
        cen_c <= c_lo;
        cen_r <= cen_r + coord_t'(1);
      end else begin
        cen_c <= cen_c + coord_t'(1);
      end
    end
  end

  assign out_valid  = (state == ST_OUT);
  assign center_row = 10'(cen_r);
  assign center_col = 10'(cen_c);
  assign std_dev    = sq_res;
  assign last       = is_last;

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while a result is pending");
  a_read_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MEAN) |-> $past(rd_vld) && $past(dcnt) == 5'(WIN_AREA - 1))
    else $error("mean computed before all window beats arrived");
  a_out_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> state == ST_READ)
    else $error("next center not started");
  a_center_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cen_r <= r_hi && cen_c <= c_hi && cen_r >= 0 && cen_c >= 0)
    else $error("center outside its range");

endmodule
